FILE: hw/rtl/sampled_name_hash_defines.svh
// Assertion macros for the sampled name hash block.
// Each expects clk and rst in scope.
`ifndef SAMPLED_NAME_HASH_DEFINES_SVH
`define SAMPLED_NAME_HASH_DEFINES_SVH

// Same-cycle implication.
`define SNH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SNH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/snh_pkg.sv
`default_nettype none

package snh_pkg;

  localparam int MAX_NAME_LEN = 256;
  localparam int IDX_W        = $clog2(MAX_NAME_LEN);
  localparam int LEN_W        = $clog2(MAX_NAME_LEN + 1);
  localparam int ADDR_W       = IDX_W + 1;
  localparam int RAM_DEPTH    = 2 ** ADDR_W;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam int          SHIFT_1     = 30;
  localparam int          SHIFT_2     = 27;
  localparam int          SHIFT_3     = 31;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       byte_present;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [63:0] name_hash;
    logic        too_long;
  } hash_item_t;

  // One finished name waiting for the hasher.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             too_long;
    logic             bank;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic        start;
    logic [63:0] din;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] dout;
  } mix_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/snh_ram.sv
`default_nettype none

module snh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/snh_fifo.sv
`default_nettype none

module snh_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  snh_pkg::job_t din,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output snh_pkg::job_t dout
);
  import snh_pkg::*;

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/snh_front.sv
`default_nettype none

module snh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  snh_pkg::byte_item_t byte_item,
  input  logic                q_full,
  output logic                push,
  output snh_pkg::job_t       job,
  output snh_pkg::ram_wr_t    ram_wr
);
  import snh_pkg::*;

  logic [LEN_W-1:0] len_count;
  logic             overflow_seen;
  logic             bank;
  logic             take;
  logic             room;
  logic             store;
  logic             spill;

  // Two banks: the next name fills one while the hasher reads the other.
  assign byte_ready = !q_full;
  assign take       = byte_valid && byte_ready;
  assign room       = (len_count != LEN_W'(MAX_NAME_LEN));
  assign store      = take && byte_item.byte_present && room;
  assign spill      = take && byte_item.byte_present && !room;

  always_comb begin
    ram_wr.en    = store;
    ram_wr.addr  = {bank, len_count[IDX_W-1:0]};
    ram_wr.data  = byte_item.name_byte;
    push         = take && byte_item.last_byte;
    job.len      = store ? len_count + LEN_W'(1) : len_count;
    job.too_long = overflow_seen || spill;
    job.bank     = bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_count     <= '0;
      overflow_seen <= 1'b0;
      bank          <= 1'b0;
    end else if (take) begin
      if (byte_item.last_byte) begin
        len_count     <= '0;
        overflow_seen <= 1'b0;
        bank          <= ~bank;
      end else begin
        if (store) begin
          len_count <= len_count + LEN_W'(1);
        end
        if (spill) begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/snh_mix.sv
`default_nettype none

module snh_mix (
  input  logic              clk,
  input  logic              rst,
  input  snh_pkg::mix_req_t req,
  output snh_pkg::mix_rsp_t rsp
);
  import snh_pkg::*;

  localparam logic [3:0] STEP_XOR_A = 4'd0;
  localparam logic [3:0] STEP_XOR_B = 4'd4;
  localparam logic [3:0] STEP_FIN   = 4'd8;

  logic        busy;
  logic [3:0]  step;
  logic [63:0] x;
  logic [63:0] p;
  logic [63:0] k;
  logic [1:0]  part;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic        done;
  logic [63:0] dout;

  // 64x64 low product in three 32x32 passes: lo*lo, then hi*lo and lo*hi into the top half.
  always_comb begin
    k    = (step < STEP_XOR_B) ? MIX_MUL_A : MIX_MUL_B;
    part = step[1:0] - 2'd1;
    op_a = (part == 2'd1) ? x[63:32] : x[31:0];
    op_b = (part == 2'd2) ? k[63:32] : k[31:0];
    prod = {32'd0, op_a} * {32'd0, op_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_XOR_A;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_XOR_A;
        x    <= req.din + GOLDEN_STEP;
        done <= 1'b0;
      end else if (busy) begin
        step <= step + 4'd1;
        done <= (step == STEP_FIN);
        unique case (step)
          STEP_XOR_A: x <= x ^ (x >> SHIFT_1);
          STEP_XOR_B: x <= p ^ (p >> SHIFT_2);
          STEP_FIN: begin
            dout <= p ^ (p >> SHIFT_3);
            busy <= 1'b0;
          end
          default: begin
            if (part == 2'd0) begin
              p <= prod;
            end else begin
              p[63:32] <= p[63:32] + prod[31:0];
            end
          end
        endcase
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.dout = dout;

endmodule

`default_nettype wire

FILE: hw/rtl/snh_back.sv
`default_nettype none

module snh_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  snh_pkg::job_t              job,
  output logic                       pop,
  output logic [snh_pkg::ADDR_W-1:0] raddr,
  input  logic [7:0]                 rdata,
  output snh_pkg::mix_req_t          mix_req,
  input  snh_pkg::mix_rsp_t          mix_rsp,
  output logic                       hash_valid,
  input  logic                       hash_ready,
  output snh_pkg::hash_item_t        hash_item
);
  import snh_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MIX_LEN   = 3'd1;
  localparam logic [2:0] S_READ      = 3'd2;
  localparam logic [2:0] S_MIX_WORD  = 3'd3;
  localparam logic [2:0] S_MIX_FINAL = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0]       state;
  logic [63:0]      h;
  logic             tl;
  logic [63:0]      word;
  logic [2:0]       wi;
  logic [3:0]       rc;
  logic [LEN_W-1:0] len;
  logic [2:0]       nwords;
  logic [IDX_W-1:0] offset;
  logic [2:0]       k;
  logic [7:0]       byte_in;
  logic [63:0]      word_full;
  logic             last_word;
  logic             out_free;

  assign len = job.len;

  always_comb begin
    priority if (len == '0) begin
      nwords = 3'd0;
    end else if (len <= LEN_W'(8)) begin
      nwords = 3'd1;
    end else if (len <= LEN_W'(16)) begin
      nwords = 3'd2;
    end else if (len <= LEN_W'(32)) begin
      nwords = 3'd4;
    end else begin
      nwords = 3'd5;
    end

    unique case (wi)
      3'd0:    offset = '0;
      3'd1:    offset = IDX_W'(len - LEN_W'(8));
      3'd2:    offset = IDX_W'(8);
      3'd3:    offset = IDX_W'((len >> 1) - LEN_W'(4));
      default: offset = IDX_W'(len - LEN_W'(16));
    endcase

    // Read data arrives in the cycle after its address; bytes past the name read as zero.
    k         = rc[2:0] - 3'd1;
    byte_in   = (LEN_W'(k) < len) ? rdata : 8'd0;
    word_full = {byte_in, word[55:0]};
    raddr     = {job.bank, offset + IDX_W'(rc[2:0])};
    last_word = (wi == nwords - 3'd1);
    out_free  = !hash_valid || hash_ready;
    pop       = (state == S_DONE) && out_free;

    mix_req.start = 1'b0;
    mix_req.din   = 64'(len);
    unique case (state)
      S_IDLE: begin
        mix_req.start = !q_empty && !job.too_long;
      end
      S_READ: begin
        mix_req.start = (rc == 4'd8);
        mix_req.din   = word_full;
      end
      S_MIX_WORD: begin
        mix_req.start = mix_rsp.done && last_word;
        mix_req.din   = h ^ mix_rsp.dout;
      end
      default: begin
        mix_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hash_valid <= 1'b0;
      wi         <= 3'd0;
      rc         <= 4'd0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        hash_valid <= 1'b1;
      end else if (hash_ready) begin
        hash_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            tl <= job.too_long;
            h  <= 64'd0;
            state <= job.too_long ? S_DONE : S_MIX_LEN;
          end
        end
        S_MIX_LEN: begin
          if (mix_rsp.done) begin
            h  <= mix_rsp.dout;
            wi <= 3'd0;
            rc <= 4'd0;
            state <= (len == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          rc <= rc + 4'd1;
          if (rc != 4'd0) begin
            word[8*k +: 8] <= byte_in;
          end
          if (rc == 4'd8) begin
            state <= S_MIX_WORD;
          end
        end
        S_MIX_WORD: begin
          if (mix_rsp.done) begin
            if (last_word) begin
              state <= S_MIX_FINAL;
            end else begin
              h     <= h ^ mix_rsp.dout;
              wi    <= wi + 3'd1;
              rc    <= 4'd0;
              state <= S_READ;
            end
          end
        end
        S_MIX_FINAL: begin
          if (mix_rsp.done) begin
            h     <= mix_rsp.dout;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            hash_item.name_hash <= h;
            hash_item.too_long  <= tl;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sampled_name_hash.sv
// channel | dir | handshake               | payload
// byte    | in  | byte_valid / byte_ready | byte_item (name_byte, byte_present, last_byte)
// hash    | out | hash_valid / hash_ready | hash_item (name_hash, too_long)
//
// Bytes go in at one per cycle while byte_ready is high, into a two-bank byte buffer.
// A name of W words (W = 1, 2, 4 or 5) is hashed by mixes on the one shared 32x32
// multiplier (three passes per 64-bit multiply), and each word is read from the buffer
// port one byte per cycle. An empty name gets only the length mix, a too-long name none;
// a stalled output adds its wait.
// Byte side stalls only while the queue holds two names, one of them being hashed.
// Reset clears control only; the buffer is not cleared and needs no clearing pass.
`default_nettype none

module sampled_name_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  snh_pkg::byte_item_t byte_item,
  output logic                hash_valid,
  input  logic                hash_ready,
  output snh_pkg::hash_item_t hash_item
);
  import snh_pkg::*;

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  job_t              job_in;
  job_t              job_head;
  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  mix_req_t          mix_req;
  mix_rsp_t          mix_rsp;

  snh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .push       (push),
    .job        (job_in),
    .ram_wr     (ram_wr)
  );

  snh_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .dout  (job_head)
  );

  snh_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  snh_mix u_mix (
    .clk (clk),
    .rst (rst),
    .req (mix_req),
    .rsp (mix_rsp)
  );

  snh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .job        (job_head),
    .pop        (pop),
    .raddr      (raddr),
    .rdata      (rdata),
    .mix_req    (mix_req),
    .mix_rsp    (mix_rsp),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_item  (hash_item)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/snh_checker.sv
`default_nettype none
`include "sampled_name_hash_defines.svh"

module snh_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_ready,
  input snh_pkg::byte_item_t byte_item,
  input logic                hash_valid,
  input logic                hash_ready,
  input snh_pkg::hash_item_t hash_item
);

  `SNH_ASSERT_NXT(a_out_hold, hash_valid && !hash_ready, hash_valid && $stable(hash_item), "hash item changed while stalled")
  `SNH_ASSERT_IMP(a_long_zero, hash_valid && hash_item.too_long, hash_item.name_hash == 64'd0, "too_long item carries nonzero hash")
  `SNH_ASSERT_IMP(a_ready_drop, $fell(byte_ready), $past(byte_valid && byte_ready && byte_item.last_byte), "byte_ready dropped without a name ending")

endmodule

bind sampled_name_hash snh_checker u_checker (.*);

`default_nettype wire
